[rtl/fif_pkg.sv]
// ----------------------------------------------------------------------------
// fif_pkg
// Widths, register codes, divider stage type and shared arithmetic helpers
// for the friction and inertia current feedforward unit.
// ----------------------------------------------------------------------------
package fif_pkg;

    localparam int CURRENT_WIDTH   = 20;
    localparam int SPEED_WIDTH     = 20;
    localparam int ACCEL_WIDTH     = 24;
    localparam int FGAIN_WIDTH     = 19;
    localparam int SMOOTH_WIDTH    = 16;
    localparam int LIMIT_WIDTH     = 19;
    localparam int IGAIN_WIDTH     = 24;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = (CURRENT_WIDTH > IGAIN_WIDTH) ? CURRENT_WIDTH : IGAIN_WIDTH;

    // gain * |speed| stays below 2^38; the quotient never exceeds the gain
    localparam int NUM_WIDTH   = FGAIN_WIDTH + SPEED_WIDTH - 1;
    localparam int QUO_WIDTH   = FGAIN_WIDTH;
    localparam int DEN_WIDTH   = SPEED_WIDTH;
    localparam int DIV_STEPS   = QUO_WIDTH;
    localparam int IPROD_WIDTH = IGAIN_WIDTH + ACCEL_WIDTH;
    localparam int ISHIFT      = 16;
    localparam int ISH_WIDTH   = IPROD_WIDTH - ISHIFT;
    localparam int WIDE_WIDTH  = 34;
    localparam int PIPE_DEPTH  = DIV_STEPS + 3;

    localparam logic [FGAIN_WIDTH-1:0]  FGAIN_RESET  = FGAIN_WIDTH'(2097);
    localparam logic [SMOOTH_WIDTH-1:0] SMOOTH_RESET = SMOOTH_WIDTH'(240);
    localparam logic [LIMIT_WIDTH-1:0]  FLIMIT_RESET = LIMIT_WIDTH'(1966);
    localparam logic [IGAIN_WIDTH-1:0]  IGAIN_RESET  = IGAIN_WIDTH'(25770);
    localparam logic [LIMIT_WIDTH-1:0]  ILIMIT_RESET = LIMIT_WIDTH'(9830);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FRICTION_GAIN,
        REG_SMOOTHING_SPEED,
        REG_FRICTION_LIMIT,
        REG_INERTIA_GAIN,
        REG_INERTIA_LIMIT,
        REG_OUTPUT_MIN,
        REG_OUTPUT_MAX
    } cfg_reg_t;

    typedef struct packed {
        logic [DEN_WIDTH-1:0]     rem;
        logic [QUO_WIDTH-1:0]     dvd;
        logic [QUO_WIDTH-1:0]     quo;
        logic [DEN_WIDTH-1:0]     den;
        logic                     neg;
        logic                     zero;
        logic [CURRENT_WIDTH-1:0] loop;
        logic [ACCEL_WIDTH-1:0]   accel;
        logic [CURRENT_WIDTH-1:0] inert;
    } div_stage_t;

    function automatic div_stage_t div_step(input div_stage_t d);
        div_stage_t           r;
        logic [DEN_WIDTH:0]   t;
        logic [DEN_WIDTH:0]   diff;
        r    = d;
        t    = {d.rem, d.dvd[QUO_WIDTH-1]};
        diff = t - {1'b0, d.den};
        if (t >= {1'b0, d.den}) begin
            r.rem = diff[DEN_WIDTH-1:0];
            r.quo = {d.quo[QUO_WIDTH-2:0], 1'b1};
        end else begin
            r.rem = t[DEN_WIDTH-1:0];
            r.quo = {d.quo[QUO_WIDTH-2:0], 1'b0};
        end
        r.dvd = {d.dvd[QUO_WIDTH-2:0], 1'b0};
        return r;
    endfunction

    // clamp to +/-lim, then saturate to the signed current range
    function automatic logic [CURRENT_WIDTH-1:0] clamp_current(
        input logic signed [WIDE_WIDTH-1:0] x,
        input logic [LIMIT_WIDTH-1:0]       lim
    );
        logic signed [WIDE_WIDTH-1:0] lim_p;
        logic signed [WIDE_WIDTH-1:0] lim_n;
        logic signed [WIDE_WIDTH-1:0] hi;
        logic signed [WIDE_WIDTH-1:0] lo;
        logic signed [WIDE_WIDTH-1:0] y;
        lim_p = signed'(WIDE_WIDTH'(lim));
        lim_n = -lim_p;
        hi    = signed'(WIDE_WIDTH'({(CURRENT_WIDTH-1){1'b1}}));
        lo    = ~hi;
        if (x > lim_p) begin
            y = lim_p;
        end else if (x < lim_n) begin
            y = lim_n;
        end else begin
            y = x;
        end
        if (y > hi) begin
            y = hi;
        end else if (y < lo) begin
            y = lo;
        end
        return y[CURRENT_WIDTH-1:0];
    endfunction

endpackage

[rtl/friction_inertia_feedforward_unit.sv]
// ----------------------------------------------------------------------------
// friction_inertia_feedforward_unit
// Friction and inertia current feedforward added to the speed-loop current,
// with symmetric and total clamps, as a fully pipelined datapath.
//
//  channel  direction  handshake          payload
//  s_       request in s_valid/s_ready    loop_current, target_speed, target_accel
//  m_       result out m_valid/m_ready    loop_current_echo, accel_echo,
//                                         friction_current, inertia_current,
//                                         total_current
//  cfg_     write      cfg_we             cfg_index, cfg_data
//
// One request per cycle unless a stall holds the pipeline. The stages are one input
// stage with both multipliers, nineteen restoring divider stages (one quotient bit
// each), one friction clamp stage and one output stage with the total clamp.
// Reset is synchronous; it clears the valid bits and the configuration registers.
// Each stage holds while its successor is full and stalled; empty stages
// keep filling, so requests are taken while a result waits on m_ready.
// ----------------------------------------------------------------------------
module friction_inertia_feedforward_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fif_pkg::CURRENT_WIDTH-1:0] s_loop_current,
    input  logic signed [fif_pkg::SPEED_WIDTH-1:0]   s_target_speed,
    input  logic signed [fif_pkg::ACCEL_WIDTH-1:0]   s_target_accel,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [fif_pkg::CURRENT_WIDTH-1:0] m_loop_current_echo,
    output logic signed [fif_pkg::ACCEL_WIDTH-1:0]   m_accel_echo,
    output logic signed [fif_pkg::CURRENT_WIDTH-1:0] m_friction_current,
    output logic signed [fif_pkg::CURRENT_WIDTH-1:0] m_inertia_current,
    output logic signed [fif_pkg::CURRENT_WIDTH-1:0] m_total_current,
    input  logic                                   cfg_we,
    input  logic [fif_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [fif_pkg::CFG_DATA_WIDTH-1:0]       cfg_data
);
    import fif_pkg::*;

    logic [FGAIN_WIDTH-1:0]          friction_gain_reg;
    logic [SMOOTH_WIDTH-1:0]         smoothing_speed_reg;
    logic [LIMIT_WIDTH-1:0]          friction_limit_reg;
    logic [IGAIN_WIDTH-1:0]          inertia_gain_reg;
    logic [LIMIT_WIDTH-1:0]          inertia_limit_reg;
    logic signed [CURRENT_WIDTH-1:0] output_min_reg;
    logic signed [CURRENT_WIDTH-1:0] output_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            friction_gain_reg   <= FGAIN_RESET;
            smoothing_speed_reg <= SMOOTH_RESET;
            friction_limit_reg  <= FLIMIT_RESET;
            inertia_gain_reg    <= IGAIN_RESET;
            inertia_limit_reg   <= ILIMIT_RESET;
            output_min_reg      <= {1'b1, {(CURRENT_WIDTH-1){1'b0}}};
            output_max_reg      <= {1'b0, {(CURRENT_WIDTH-1){1'b1}}};
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRICTION_GAIN:   friction_gain_reg   <= cfg_data[FGAIN_WIDTH-1:0];
                REG_SMOOTHING_SPEED: smoothing_speed_reg <= cfg_data[SMOOTH_WIDTH-1:0];
                REG_FRICTION_LIMIT:  friction_limit_reg  <= cfg_data[LIMIT_WIDTH-1:0];
                REG_INERTIA_GAIN:    inertia_gain_reg    <= cfg_data[IGAIN_WIDTH-1:0];
                REG_INERTIA_LIMIT:   inertia_limit_reg   <= cfg_data[LIMIT_WIDTH-1:0];
                REG_OUTPUT_MIN:      output_min_reg      <= cfg_data[CURRENT_WIDTH-1:0];
                REG_OUTPUT_MAX:      output_max_reg      <= cfg_data[CURRENT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage advance chain
    logic                 s0_adv;
    logic [DIV_STEPS-1:0] div_adv;
    logic                 f_adv;
    logic                 o_adv;

    logic                 s0_valid_reg;
    logic [DIV_STEPS-1:0] div_valid_reg;
    logic                 f_valid_reg;
    logic                 o_valid_reg;

    assign o_adv   = !o_valid_reg || m_ready;
    assign f_adv   = !f_valid_reg || o_adv;
    assign s0_adv  = !s0_valid_reg || div_adv[0];
    assign s_ready = s0_adv;

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_adv
            if (k == DIV_STEPS - 1) begin : g_last
                assign div_adv[k] = !div_valid_reg[k] || f_adv;
            end else begin : g_mid
                assign div_adv[k] = !div_valid_reg[k] || div_adv[k+1];
            end
        end
    endgenerate

    // input stage: magnitudes and both products
    logic [SPEED_WIDTH-1:0]        spd_abs;
    logic [NUM_WIDTH-1:0]          num_full;
    logic [DEN_WIDTH-1:0]          den_sum;
    logic signed [IPROD_WIDTH-1:0] iprod;

    always_comb begin
        spd_abs  = s_target_speed[SPEED_WIDTH-1] ? SPEED_WIDTH'(-s_target_speed)
                                                 : SPEED_WIDTH'(s_target_speed);
        num_full = NUM_WIDTH'(friction_gain_reg) * NUM_WIDTH'(spd_abs);
        den_sum  = DEN_WIDTH'(spd_abs) + DEN_WIDTH'(smoothing_speed_reg);
        iprod    = IPROD_WIDTH'($signed({1'b0, inertia_gain_reg}))
                 * IPROD_WIDTH'(s_target_accel);
    end

    logic [NUM_WIDTH-1:0]          s0_num_reg;
    logic [DEN_WIDTH-1:0]          s0_den_reg;
    logic                          s0_neg_reg;
    logic                          s0_zero_reg;
    logic [CURRENT_WIDTH-1:0]      s0_loop_reg;
    logic [ACCEL_WIDTH-1:0]        s0_accel_reg;
    logic signed [IPROD_WIDTH-1:0] s0_iprod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s0_adv) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_adv) begin
            s0_num_reg   <= num_full;
            s0_den_reg   <= den_sum;
            s0_neg_reg   <= s_target_speed[SPEED_WIDTH-1];
            s0_zero_reg  <= (s_target_speed == '0);
            s0_loop_reg  <= s_loop_current;
            s0_accel_reg <= s_target_accel;
            s0_iprod_reg <= iprod;
        end
    end

    // divider entry; the inertia clamp rides alongside the first step
    logic signed [ISH_WIDTH-1:0]  ish;
    logic signed [WIDE_WIDTH-1:0] ish_wide;
    div_stage_t                   div_in;

    always_comb begin
        ish          = s0_iprod_reg[IPROD_WIDTH-1:ISHIFT];
        ish_wide     = WIDE_WIDTH'(ish);
        div_in.rem   = DEN_WIDTH'(s0_num_reg[NUM_WIDTH-1:QUO_WIDTH]);
        div_in.dvd   = s0_num_reg[QUO_WIDTH-1:0];
        div_in.quo   = '0;
        div_in.den   = s0_den_reg;
        div_in.neg   = s0_neg_reg;
        div_in.zero  = s0_zero_reg;
        div_in.loop  = s0_loop_reg;
        div_in.accel = s0_accel_reg;
        div_in.inert = clamp_current(ish_wide, inertia_limit_reg);
    end

    div_stage_t div_reg [DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg <= '0;
        end else begin
            if (div_adv[0]) begin
                div_valid_reg[0] <= s0_valid_reg;
            end
            for (int i = 1; i < DIV_STEPS; i++) begin
                if (div_adv[i]) begin
                    div_valid_reg[i] <= div_valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_adv[0]) begin
            div_reg[0] <= div_step(div_in);
        end
        for (int i = 1; i < DIV_STEPS; i++) begin
            if (div_adv[i]) begin
                div_reg[i] <= div_step(div_reg[i-1]);
            end
        end
    end

    // friction sign and clamp
    div_stage_t                   div_last;
    logic signed [WIDE_WIDTH-1:0] quo_wide;
    logic signed [WIDE_WIDTH-1:0] fric_wide;

    always_comb begin
        div_last = div_reg[DIV_STEPS-1];
        quo_wide = signed'(WIDE_WIDTH'(div_last.quo));
        if (div_last.zero) begin
            fric_wide = '0;
        end else if (div_last.neg) begin
            fric_wide = -quo_wide;
        end else begin
            fric_wide = quo_wide;
        end
    end

    logic [CURRENT_WIDTH-1:0] f_fric_reg;
    logic [CURRENT_WIDTH-1:0] f_inert_reg;
    logic [CURRENT_WIDTH-1:0] f_loop_reg;
    logic [ACCEL_WIDTH-1:0]   f_accel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_adv) begin
            f_valid_reg <= div_valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (f_adv) begin
            f_fric_reg  <= clamp_current(fric_wide, friction_limit_reg);
            f_inert_reg <= div_last.inert;
            f_loop_reg  <= div_last.loop;
            f_accel_reg <= div_last.accel;
        end
    end

    // total and its clamp
    logic signed [CURRENT_WIDTH+1:0] sum;
    logic signed [CURRENT_WIDTH+1:0] max_wide;
    logic signed [CURRENT_WIDTH+1:0] min_wide;
    logic signed [CURRENT_WIDTH+1:0] total_wide;

    always_comb begin
        sum = (CURRENT_WIDTH+2)'($signed(f_loop_reg))
            + (CURRENT_WIDTH+2)'($signed(f_fric_reg))
            + (CURRENT_WIDTH+2)'($signed(f_inert_reg));
        max_wide = (CURRENT_WIDTH+2)'(output_max_reg);
        min_wide = (CURRENT_WIDTH+2)'(output_min_reg);
        if (sum > max_wide) begin
            total_wide = max_wide;
        end else if (sum < min_wide) begin
            total_wide = min_wide;
        end else begin
            total_wide = sum;
        end
    end

    logic [CURRENT_WIDTH-1:0] o_loop_reg;
    logic [ACCEL_WIDTH-1:0]   o_accel_reg;
    logic [CURRENT_WIDTH-1:0] o_fric_reg;
    logic [CURRENT_WIDTH-1:0] o_inert_reg;
    logic [CURRENT_WIDTH-1:0] o_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_adv) begin
            o_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_adv) begin
            o_loop_reg  <= f_loop_reg;
            o_accel_reg <= f_accel_reg;
            o_fric_reg  <= f_fric_reg;
            o_inert_reg <= f_inert_reg;
            o_total_reg <= total_wide[CURRENT_WIDTH-1:0];
        end
    end

    assign m_valid             = o_valid_reg;
    assign m_loop_current_echo = o_loop_reg;
    assign m_accel_echo        = o_accel_reg;
    assign m_friction_current  = o_fric_reg;
    assign m_inertia_current   = o_inert_reg;
    assign m_total_current     = o_total_reg;

endmodule

[rtl/fif_checker.sv]
// ----------------------------------------------------------------------------
// fif_checker
// Port-level checks on the feedforward unit: reset, occupancy and output hold.
// ----------------------------------------------------------------------------
module fif_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [fif_pkg::CURRENT_WIDTH-1:0] m_total_current
);
    import fif_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> cnt_reg != '0)
        else $error("result delivered with no request in flight");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && !out_acc |-> cnt_reg < CNT_W'(PIPE_DEPTH))
        else $error("request taken beyond pipeline capacity");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_current))
        else $error("stalled result dropped or changed");

endmodule

bind friction_inertia_feedforward_unit fif_checker u_fif_checker (.*);

[bench/friction_inertia_feedforward_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// friction_inertia_feedforward_unit_tb
// Self-checking bench for the friction and inertia current feedforward unit.
// Requests are queued per register setting and driven through the s_ channel
// with random gaps, while m_ready is withheld at random. Every accepted request
// is run through a local bit-accurate predictor of the friction, inertia and
// total currents, and each result is compared field by field in order.
// Register settings cover reset values, extremes, a zero smoothing constant,
// an inverted total clamp, an unused register index and random values.
// ----------------------------------------------------------------------------
module friction_inertia_feedforward_unit_tb;

    import fif_pkg::*;

    localparam int CUR_MAX = (1 << (CURRENT_WIDTH - 1)) - 1;
    localparam int CUR_MIN = -CUR_MAX - 1;
    localparam int SPD_MAX = (1 << (SPEED_WIDTH - 1)) - 1;
    localparam int SPD_MIN = -SPD_MAX - 1;
    localparam int ACC_MAX = (1 << (ACCEL_WIDTH - 1)) - 1;
    localparam int ACC_MIN = -ACC_MAX - 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = CFG_INDEX_WIDTH'(7);

    localparam int NUM_PHASES       = 9;
    localparam int RANDOM_PER_PHASE = 55;
    localparam int MAX_ERR_LINES    = 40;

    typedef struct {
        logic signed [CURRENT_WIDTH-1:0] loop_current;
        logic signed [SPEED_WIDTH-1:0]   target_speed;
        logic signed [ACCEL_WIDTH-1:0]   target_accel;
    } ff_request_t;

    typedef struct {
        logic signed [CURRENT_WIDTH-1:0] loop_current_echo;
        logic signed [ACCEL_WIDTH-1:0]   accel_echo;
        logic signed [CURRENT_WIDTH-1:0] friction_current;
        logic signed [CURRENT_WIDTH-1:0] inertia_current;
        logic signed [CURRENT_WIDTH-1:0] total_current;
    } ff_result_t;

    logic                              aclk;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic signed [CURRENT_WIDTH-1:0]   s_loop_current = '0;
    logic signed [SPEED_WIDTH-1:0]     s_target_speed = '0;
    logic signed [ACCEL_WIDTH-1:0]     s_target_accel = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    logic signed [CURRENT_WIDTH-1:0]   m_loop_current_echo;
    logic signed [ACCEL_WIDTH-1:0]     m_accel_echo;
    logic signed [CURRENT_WIDTH-1:0]   m_friction_current;
    logic signed [CURRENT_WIDTH-1:0]   m_inertia_current;
    logic signed [CURRENT_WIDTH-1:0]   m_total_current;
    logic                              cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]        cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]         cfg_data  = '0;

    // register copy used by the predictor
    logic [FGAIN_WIDTH-1:0]            fgain_q   = FGAIN_RESET;
    logic [SMOOTH_WIDTH-1:0]           smooth_q  = SMOOTH_RESET;
    logic [LIMIT_WIDTH-1:0]            flimit_q  = FLIMIT_RESET;
    logic [IGAIN_WIDTH-1:0]            igain_q   = IGAIN_RESET;
    logic [LIMIT_WIDTH-1:0]            ilimit_q  = ILIMIT_RESET;
    logic signed [CURRENT_WIDTH-1:0]   omin_q    = CURRENT_WIDTH'(CUR_MIN);
    logic signed [CURRENT_WIDTH-1:0]   omax_q    = CURRENT_WIDTH'(CUR_MAX);

    ff_request_t pending_requests[$];
    ff_result_t  expected_results[$];
    ff_request_t request_on_bus;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;

    friction_inertia_feedforward_unit DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_loop_current      (s_loop_current),
        .s_target_speed      (s_target_speed),
        .s_target_accel      (s_target_accel),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_loop_current_echo (m_loop_current_echo),
        .m_accel_echo        (m_accel_echo),
        .m_friction_current  (m_friction_current),
        .m_inertia_current   (m_inertia_current),
        .m_total_current     (m_total_current),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint clamp_to_current(input longint x, input longint lim);
        longint y;
        y = x;
        if (y > lim) begin
            y = lim;
        end else if (y < -lim) begin
            y = -lim;
        end
        if (y > CUR_MAX) begin
            y = CUR_MAX;
        end else if (y < CUR_MIN) begin
            y = CUR_MIN;
        end
        return y;
    endfunction

    function automatic ff_result_t predict_feedforward(input ff_request_t r);
        ff_result_t res;
        longint     loop_i;
        longint     speed;
        longint     accel;
        longint     den;
        longint     fg;
        longint     ig;
        longint     fric;
        longint     inert;
        longint     total;
        loop_i = r.loop_current;
        speed  = r.target_speed;
        accel  = r.target_accel;
        fg     = fgain_q;
        ig     = igain_q;
        den    = (speed < 0) ? -speed : speed;
        den    = den + longint'(smooth_q);
        fric   = (den != 0) ? (fg * speed) / den : 0;
        fric   = clamp_to_current(fric, longint'(flimit_q));
        inert  = (ig * accel) >>> ISHIFT;
        inert  = clamp_to_current(inert, longint'(ilimit_q));
        total  = loop_i + fric + inert;
        if (total > omax_q) begin
            total = omax_q;
        end else if (total < omin_q) begin
            total = omin_q;
        end
        res.loop_current_echo = r.loop_current;
        res.accel_echo        = r.target_accel;
        res.friction_current  = fric[CURRENT_WIDTH-1:0];
        res.inertia_current   = inert[CURRENT_WIDTH-1:0];
        res.total_current     = total[CURRENT_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_ERR_LINES) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic queue_request(input int loop_i, input int speed, input int accel);
        ff_request_t r;
        r.loop_current = CURRENT_WIDTH'(loop_i);
        r.target_speed = SPEED_WIDTH'(speed);
        r.target_accel = ACCEL_WIDTH'(accel);
        pending_requests.push_back(r);
    endtask

    task automatic queue_random_request();
        int loop_i;
        int speed;
        int accel;
        case ($urandom_range(3))
            0: loop_i = int'($urandom_range(20000)) - 10000;
            1: loop_i = $urandom_range(1) ? CUR_MAX : CUR_MIN;
            default: loop_i = $urandom;
        endcase
        case ($urandom_range(4))
            0: speed = int'($urandom_range(4000)) - 2000;
            1: speed = int'($urandom_range(8)) - 4;
            2: speed = $urandom_range(1) ? SPD_MAX : SPD_MIN;
            default: speed = $urandom;
        endcase
        case ($urandom_range(3))
            0: accel = int'($urandom_range(600000)) - 300000;
            1: accel = int'($urandom_range(8)) - 4;
            default: accel = $urandom;
        endcase
        queue_request(loop_i, speed, accel);
    endtask

    // update the register copy alongside the write so both match once it lands
    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_WIDTH'(value);
        case (idx)
            REG_FRICTION_GAIN:   fgain_q  = value[FGAIN_WIDTH-1:0];
            REG_SMOOTHING_SPEED: smooth_q = value[SMOOTH_WIDTH-1:0];
            REG_FRICTION_LIMIT:  flimit_q = value[LIMIT_WIDTH-1:0];
            REG_INERTIA_GAIN:    igain_q  = value[IGAIN_WIDTH-1:0];
            REG_INERTIA_LIMIT:   ilimit_q = value[LIMIT_WIDTH-1:0];
            REG_OUTPUT_MIN:      omin_q   = value[CURRENT_WIDTH-1:0];
            REG_OUTPUT_MAX:      omax_q   = value[CURRENT_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic program_all(input int fg, input int ss, input int fl, input int ig,
                               input int il, input int lo, input int hi);
        cfg_write(REG_FRICTION_GAIN, fg);
        cfg_write(REG_SMOOTHING_SPEED, ss);
        cfg_write(REG_FRICTION_LIMIT, fl);
        cfg_write(REG_INERTIA_GAIN, ig);
        cfg_write(REG_INERTIA_LIMIT, il);
        cfg_write(REG_OUTPUT_MIN, lo);
        cfg_write(REG_OUTPUT_MAX, hi);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // driver: hold a request until taken, then advance or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_feedforward(request_on_bus));
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    request_on_bus = pending_requests.pop_front();
                    s_valid        <= 1'b1;
                    s_loop_current <= request_on_bus.loop_current;
                    s_target_speed <= request_on_bus.target_speed;
                    s_target_accel <= request_on_bus.target_accel;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        ff_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_error("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("loop_current_echo", m_loop_current_echo,
                                want.loop_current_echo);
                    check_field("accel_echo", m_accel_echo, want.accel_echo);
                    check_field("friction_current", m_friction_current,
                                want.friction_current);
                    check_field("inertia_current", m_inertia_current,
                                want.inertia_current);
                    check_field("total_current", m_total_current, want.total_current);
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        int phase;
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 3) begin
                sender_idle_pct    = 38;
                receiver_stall_pct = 88;
            end else if (phase < 6) begin
                sender_idle_pct    = 88;
                receiver_stall_pct = 38;
            end else begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end

            case (phase)
                0: begin
                    queue_request(0, 0, 0);
                    queue_request(CUR_MAX, SPD_MAX, ACC_MAX);
                    queue_request(CUR_MIN, SPD_MIN, ACC_MIN);
                    queue_request(0, 1, 1);
                    queue_request(0, -1, -1);
                    queue_request(0, 240, 0);
                    queue_request(0, -240, 0);
                    queue_request(-1, 0, ACC_MAX);
                    queue_request(0, 0, ACC_MIN);
                    queue_request(CUR_MAX, 0, 0);
                    queue_request(CUR_MIN, 0, 0);
                    queue_request(CUR_MAX, 3000, 200000);
                    queue_request(CUR_MIN, -3000, -200000);
                    queue_request(12345, -5000, 100000);
                end
                1: program_all(2**FGAIN_WIDTH - 1, 1, 2**LIMIT_WIDTH - 1,
                               2**IGAIN_WIDTH - 1, 2**LIMIT_WIDTH - 1, CUR_MIN, CUR_MAX);
                2: begin
                    // zero smoothing: a zero speed must give no friction current
                    program_all(2**FGAIN_WIDTH - 1, 0, 2**LIMIT_WIDTH - 1, 0, 0,
                                CUR_MIN, CUR_MAX);
                    queue_request(0, 0, 0);
                    queue_request(1, 0, -1);
                    queue_request(0, 1, 1);
                    queue_request(0, -1, ACC_MAX);
                end
                3: begin
                    // inverted total clamp, then a write to the unused index
                    program_all(0, 2**SMOOTH_WIDTH - 1, 0, 1, 2**LIMIT_WIDTH - 1,
                                1000, -1000);
                    cfg_write(REG_UNUSED, $urandom);
                    @(posedge aclk);
                    cfg_we <= 1'b0;
                end
                4: program_all(100000, 5000, 60000, 3000000, 200000, -300000, 300000);
                default: program_all($urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom);
            endcase

            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                queue_random_request();
            end
            wait_drained();
        end

        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
